@@ design/xcpf_pkg.sv @@
// Package for the XMODEM CRC packet framer: packet size, framing constants,
// queue entry and status types, back-end phase enum and the CRC-16 byte update.
// Has no dependencies; every other design file imports it.
`timescale 1ns / 1ps

package xcpf_pkg;

  // Data bytes per packet (legal range 2 to 1024).
  localparam int PACKET_BYTES = 128;
  localparam int POS_W        = (PACKET_BYTES > 2) ? $clog2(PACKET_BYTES) : 1;

  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [7:0]  START_BYTE      = 8'h01;
  localparam logic [7:0]  FIRST_SEQ_RESET = 8'h01;

  // Queue between front and back end; the depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // One classified data byte waiting for the back end.
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  seq;
    logic [15:0] crc;
    logic        first;
    logic        last;
  } q_entry_t;

  // Queue fill status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Byte slot that the back end emits next for the entry at the queue head.
  typedef enum logic [2:0] {
    PH_FRESH,
    PH_START,
    PH_SEQ,
    PH_NSEQ,
    PH_DATA,
    PH_CRCH,
    PH_CRCL
  } phase_t;

  // CRC-16/XMODEM update with one byte, MSB first.
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ design/xcpf_front.sv @@
// Front end of the packet framer: accepts data bytes, tracks packet position,
// sequence number and running CRC, and pushes one classified entry per byte.
// Depends on xcpf_pkg.
`timescale 1ns / 1ps

module xcpf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tuser,
  input  xcpf_pkg::q_status_t q_stat,
  output logic                push,
  output xcpf_pkg::q_entry_t  push_entry
);
  import xcpf_pkg::*;

  logic [7:0]       first_seq_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             at_first, at_last;
  logic [7:0]       seq_eff;
  logic [15:0]      crc_base;

  // A byte is taken whenever the queue has room.
  assign in_tready = ~q_stat.full;
  assign push      = in_tvalid & in_tready;

  // Classify the byte and fold it into the CRC.
  assign at_first = (pos_r == '0);
  assign at_last  = (pos_r == POS_W'(PACKET_BYTES - 1));
  assign seq_eff  = (at_first && in_tuser) ? first_seq_r : seq_r;
  assign crc_base = at_first ? 16'h0000 : crc_r;
  assign crc_nxt  = crc_add_byte(crc_base, in_tdata);
  assign seq_nxt  = at_last ? (seq_eff + 8'd1) : seq_eff;
  assign pos_nxt  = at_last ? '0 : (pos_r + POS_W'(1));

  always_comb begin
    push_entry.data  = in_tdata;
    push_entry.seq   = seq_eff;
    push_entry.crc   = crc_nxt;
    push_entry.first = at_first;
    push_entry.last  = at_last;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_seq_r <= FIRST_SEQ_RESET;
    end else if (cfg_we) begin
      first_seq_r <= cfg_wdata;
    end
  end

  // Packet state advances on each accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      seq_r <= FIRST_SEQ_RESET;
      crc_r <= 16'h0000;
    end else if (push) begin
      pos_r <= pos_nxt;
      seq_r <= seq_nxt;
      crc_r <= crc_nxt;
    end
  end

endmodule

@@ design/xcpf_queue.sv @@
// Short queue of classified entries between the framer's front and back end.
// Depends on xcpf_pkg.
`timescale 1ns / 1ps

module xcpf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  xcpf_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output xcpf_pkg::q_entry_t  head,
  output xcpf_pkg::q_status_t q_stat
);
  import xcpf_pkg::*;

  q_entry_t           slot_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  assign q_stat.full  = (count_r == Q_CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = slot_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

@@ design/xcpf_back.sv @@
// Back end of the packet framer: walks the entry at the queue head through its
// header, data and CRC bytes, one byte per transfer into the output register.
// Depends on xcpf_pkg.
`timescale 1ns / 1ps

module xcpf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  xcpf_pkg::q_entry_t  head,
  input  xcpf_pkg::q_status_t q_stat,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  output logic                out_tuser
);
  import xcpf_pkg::*;

  phase_t     phase_r, phase_nxt;
  phase_t     phase_eff;
  logic       load, emit, final_byte;
  logic [7:0] byte_sel;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_end_r, out_run_r;

  // The output register takes a new byte when empty or being drained.
  assign load = ~out_valid_r | out_tready;
  assign emit = load & ~q_stat.empty;
  assign pop  = emit & final_byte;

  // A fresh head starts at the header or directly at its data byte.
  assign phase_eff = (phase_r == PH_FRESH) ? (head.first ? PH_START : PH_DATA) : phase_r;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (emit) begin
      if (final_byte) begin
        phase_nxt = PH_FRESH;
      end else begin
        unique case (phase_eff)
          PH_START: phase_nxt = PH_SEQ;
          PH_SEQ:   phase_nxt = PH_NSEQ;
          PH_NSEQ:  phase_nxt = PH_DATA;
          PH_DATA:  phase_nxt = PH_CRCH;
          PH_CRCH:  phase_nxt = PH_CRCL;
          default:  phase_nxt = PH_FRESH;
        endcase
      end
    end
  end

  // Byte and flags for the current phase.
  always_comb begin
    byte_sel   = head.data;
    final_byte = 1'b0;
    unique case (phase_eff)
      PH_START: byte_sel = START_BYTE;
      PH_SEQ:   byte_sel = head.seq;
      PH_NSEQ:  byte_sel = ~head.seq;
      PH_DATA: begin
        byte_sel   = head.data;
        final_byte = ~head.last;
      end
      PH_CRCH:  byte_sel = head.crc[15:8];
      PH_CRCL: begin
        byte_sel   = head.crc[7:0];
        final_byte = 1'b1;
      end
      default: begin
        byte_sel   = head.data;
        final_byte = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FRESH;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= ~q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_sel;
      out_end_r  <= (phase_eff == PH_CRCL);
      out_run_r  <= final_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_end_r;
  assign out_tuser  = out_run_r;

  a_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser)
    else $error("packet end not marked as last byte of its run");

  a_busy_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_FRESH) |-> !q_stat.empty)
    else $error("back end mid-entry with empty queue");

  a_crc_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CRCH || phase_r == PH_CRCL) |-> head.last)
    else $error("CRC bytes emitted for an entry that does not close a packet");

endmodule

@@ design/xmodem_crc_packet_framer_top.sv @@
// Top level of the XMODEM CRC packet framer: front end, entry queue, back end.
// Depends on xcpf_pkg, xcpf_front, xcpf_queue and xcpf_back.
`timescale 1ns / 1ps

// Usage:
// The input stream carries one firmware byte per transfer in in_tdata, with
// in_tuser set to restart the sequence at first_sequence; that flag counts only
// on the first byte of a packet. cfg_we with cfg_wdata writes first_sequence.
// The output stream carries the framed bytes in out_tdata: start byte, sequence
// number and its complement before each packet's first data byte, and the
// CRC-16 high then low byte after its last. out_tuser marks the last byte caused
// by one input transfer; out_tlast marks the CRC low byte closing a packet.
// The first output byte of an input transfer passes through the queue and then
// the back end's output register. The back end gives one output byte per cycle
// while the receiver is ready and the queue holds an entry, set by its single
// output register; the first and last transfers of a packet add header and CRC
// bytes, so a packet of 128 data bytes yields 133 output bytes.
// Reset (rst_n low, synchronous) clears the packet position, the CRC and the
// queue, and sets the sequence number and first_sequence to 1.
// When the receiver stalls, the output byte holds and the two-entry queue
// fills; in_tready then drops until the back end drains an entry.

module xmodem_crc_packet_framer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,   // first_sequence
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic       in_tuser,    // [0] new_image
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] frame_byte
  output logic       out_tlast,   // packet_end
  output logic       out_tuser    // [0] last_of_run
);
  import xcpf_pkg::*;

  q_status_t q_stat;
  q_entry_t  push_entry, head;
  logic      push, pop;

  xcpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  xcpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  xcpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
